// ===== rtl/bscmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bscmc_pkg
// Field widths and fixed constants for the set cover cost engine.
// ----------------------------------------------------------------------------
package bscmc_pkg;

  localparam int KEY_COST_W   = 20;
  localparam int KEY_MASK_W   = 12;
  localparam int ITEM_CNT_W   = 4;
  localparam int OUT_COST_W   = 31;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [ITEM_CNT_W-1:0] ITEM_CNT_RST = 4'd12;

endpackage

// ===== rtl/bscmc_table.sv =====
// ----------------------------------------------------------------------------
// bscmc_table
// Best-cost table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bscmc_table #(
  parameter int ADDR_W    = 12,
  parameter int COST_BITS = 31
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [COST_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr0,
  input  logic [ADDR_W-1:0]    raddr1,
  output logic [COST_BITS-1:0] rdata0,
  output logic [COST_BITS-1:0] rdata1
);

  logic [COST_BITS-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== rtl/bscmc_relax.sv =====
// ----------------------------------------------------------------------------
// bscmc_relax
// Relax stage: saturating add of the key cost, compare against the target
// entry, write back the lower cost. Forwards the previous write.
// ----------------------------------------------------------------------------
module bscmc_relax #(
  parameter int ADDR_W    = 12,
  parameter int COST_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                iss_vld,
  input  logic [ADDR_W-1:0]                   iss_m,
  input  logic [ADDR_W-1:0]                   iss_t,
  input  logic [bscmc_pkg::KEY_COST_W-1:0]    key_cost,
  input  logic [COST_BITS-1:0]                rd_m,
  input  logic [COST_BITS-1:0]                rd_t,
  output logic                                we,
  output logic [ADDR_W-1:0]                   waddr,
  output logic [COST_BITS-1:0]                wdata
);

  import bscmc_pkg::*;

  localparam int SUM_W = ((COST_BITS > KEY_COST_W) ? COST_BITS : KEY_COST_W) + 1;
  localparam logic [COST_BITS-1:0] ONES = {COST_BITS{1'b1}};

  logic                 p_vld_r;
  logic [ADDR_W-1:0]    p_m_r;
  logic [ADDR_W-1:0]    p_t_r;
  logic                 fw_vld_r;
  logic [ADDR_W-1:0]    fw_addr_r;
  logic [COST_BITS-1:0] fw_data_r;

  logic [COST_BITS-1:0] val_m;
  logic [COST_BITS-1:0] val_t;
  logic [SUM_W-1:0]     sum;
  logic [COST_BITS-1:0] cand;
  logic                 upd;

  always_comb begin
    val_m = (fw_vld_r && (fw_addr_r == p_m_r)) ? fw_data_r : rd_m;
    val_t = (fw_vld_r && (fw_addr_r == p_t_r)) ? fw_data_r : rd_t;
    sum   = SUM_W'(val_m) + SUM_W'(key_cost);
    cand  = (sum >= SUM_W'(ONES)) ? ONES : COST_BITS'(sum);
    upd   = p_vld_r && (cand < val_t);
  end

  assign we    = upd;
  assign waddr = p_t_r;
  assign wdata = cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      p_vld_r  <= iss_vld;
      fw_vld_r <= upd;
    end
    p_m_r     <= iss_m;
    p_t_r     <= iss_t;
    fw_addr_r <= p_t_r;
    fw_data_r <= cand;
  end

endmodule

// ===== rtl/bitmask_set_cover_min_cost.sv =====
// ----------------------------------------------------------------------------
// bitmask_set_cover_min_cost
// Weighted set cover by bitmask DP over an in-memory best-cost table.
//
//   channel | ports        | payload (low bit up)
//   --------+--------------+------------------------------------------
//   in      | in_t*        | tdata: key_cost, key_mask; tlast: last_key
//   out     | out_t*       | tdata: min_total_cost, reachable
//   cfg     | cfg_wen/wdata| item_count
//
// A key sweeps all 2^n masks, n the live item count: one table
// read-modify-write per mask through the two-read, one-write table memory.
// A last key adds an answer read, then a clear pass over all
// 2^MAX_ITEMS entries with in_tready low. Reset starts the same clear pass.
// A waiting answer holds the next answer back; the clear pass proceeds.
// ----------------------------------------------------------------------------
module bitmask_set_cover_min_cost #(
  parameter int MAX_ITEMS = 12,
  parameter int COST_BITS = 31
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bscmc_pkg::IN_TDATA_W-1:0]     in_tdata,   // key_cost, key_mask
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bscmc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // min_total_cost, reachable
  input  logic                                 cfg_wen,
  input  logic [bscmc_pkg::ITEM_CNT_W-1:0]     cfg_wdata
);

  import bscmc_pkg::*;

  localparam int ADDR_W = MAX_ITEMS;
  localparam logic [COST_BITS-1:0] ONES = {COST_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_AREAD = 3'd3;
  localparam logic [2:0] S_ANS   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [ITEM_CNT_W-1:0]  item_count_r;
  logic [ADDR_W-1:0]      m_r, m_nxt;
  logic [ADDR_W-1:0]      clr_r, clr_nxt;
  logic [ADDR_W-1:0]      full_r;
  logic [ADDR_W-1:0]      kmask_r;
  logic [KEY_COST_W-1:0]  cost_r;
  logic                   last_r;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [4:0]             n_live;
  logic [ADDR_W-1:0]      full_w;
  logic                   accept;
  logic                   ans_load;

  logic                   iss_vld;
  logic [ADDR_W-1:0]      raddr0, raddr1;
  logic [COST_BITS-1:0]   rdata0, rdata1;
  logic                   rlx_we;
  logic [ADDR_W-1:0]      rlx_waddr;
  logic [COST_BITS-1:0]   rlx_wdata;
  logic                   tbl_we;
  logic [ADDR_W-1:0]      tbl_waddr;
  logic [COST_BITS-1:0]   tbl_wdata;
  logic                   reach;

  always_comb begin
    n_live = (item_count_r > MAX_ITEMS) ? 5'(MAX_ITEMS) : {1'b0, item_count_r};
    full_w = ~({ADDR_W{1'b1}} << n_live);
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign ans_load  = (state_r == S_ANS) && !out_vld_r;

  assign iss_vld = (state_r == S_SWEEP);
  assign raddr0  = (state_r == S_SWEEP) ? m_r : full_r;
  assign raddr1  = m_r | kmask_r;

  assign tbl_we    = (state_r == S_CLEAR) ? 1'b1 : rlx_we;
  assign tbl_waddr = (state_r == S_CLEAR) ? clr_r : rlx_waddr;
  assign tbl_wdata = (state_r == S_CLEAR) ? ((clr_r == '0) ? '0 : ONES) : rlx_wdata;

  assign reach = (rdata0 != ONES);

  bscmc_table #(
    .ADDR_W    (ADDR_W),
    .COST_BITS (COST_BITS)
  ) u_table (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (tbl_waddr),
    .wdata  (tbl_wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  bscmc_relax #(
    .ADDR_W    (ADDR_W),
    .COST_BITS (COST_BITS)
  ) u_relax (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_vld  (iss_vld),
    .iss_m    (raddr0),
    .iss_t    (raddr1),
    .key_cost (cost_r),
    .rd_m     (rdata0),
    .rd_t     (rdata1),
    .we       (rlx_we),
    .waddr    (rlx_waddr),
    .wdata    (rlx_wdata)
  );

  always_comb begin
    state_nxt   = state_r;
    m_nxt       = m_r;
    clr_nxt     = clr_r;
    out_vld_nxt = out_vld_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SWEEP;
          m_nxt     = '0;
        end
      end
      S_SWEEP: begin
        if (m_r == full_r) begin
          state_nxt = S_DRAIN;
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = last_r ? S_AREAD : S_IDLE;
      end
      S_AREAD: begin
        state_nxt = S_ANS;
      end
      S_ANS: begin
        if (ans_load) begin
          out_vld_nxt = 1'b1;
          clr_nxt     = '0;
          state_nxt   = S_CLEAR;
        end
      end
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {ADDR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      m_r          <= '0;
      out_vld_r    <= 1'b0;
      item_count_r <= ITEM_CNT_RST;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      m_r       <= m_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wen) begin
        item_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cost_r  <= in_tdata[KEY_COST_W-1:0];
      kmask_r <= ADDR_W'(in_tdata[KEY_COST_W +: KEY_MASK_W]) & full_w;
      full_r  <= full_w;
      last_r  <= in_tlast;
    end
    if (ans_load) begin
      out_data_r <= {reach, (reach ? OUT_COST_W'(rdata0) : {OUT_COST_W{1'b0}})};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_out_from_ans: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_ANS)
    else $error("result raised outside answer state");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (m_r & ~full_r) == '0)
    else $error("sweep index beyond live mask range");

  a_kmask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (kmask_r & ~full_r) == '0)
    else $error("key mask beyond live item range");

  a_no_relax_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !rlx_we)
    else $error("relax write during clear pass");
`endif

endmodule
